@@ rtl/core/tlpw_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared types and constants of the two-level page walk memory unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpw_pkg;

    localparam int MEM_ADDR_BITS_DEF = 16;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [1:0] {
        OP_VREAD  = 2'd0,
        OP_VWRITE = 2'd1,
        OP_PREAD  = 2'd2,
        OP_PWRITE = 2'd3
    } t_op;

    typedef enum logic {
        CFG_PAGING   = 1'b0,
        CFG_DIR_BASE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic ld_item;
        logic walk_dir;
        logic walk_tab;
        logic set_base;
        logic set_second;
        logic set_fault;
        logic mem_acc;
        logic cap_read;
        logic set_out;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic translate;
        logic split;
        logic second;
        logic present;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/tlpw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpw_ctrl
// Sequencer: runs an item through any walk, access and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpw_ctrl import tlpw_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  wire   i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_TAB   = 7'b0000100,
        S_BASE  = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_CAP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_stat.len_zero) begin
                    n_state = S_DONE;
                end else if (!i_stat.translate) begin
                    n_state = S_ACC;
                end else begin
                    o_cmd.walk_dir = 1'b1;
                    n_state = S_TAB;
                end
            end
            S_TAB: begin
                if (!i_stat.present) begin
                    o_cmd.set_fault = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.walk_tab = 1'b1;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                if (!i_stat.present) begin
                    o_cmd.set_fault = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.set_base = 1'b1;
                    if (i_stat.split && !i_stat.second) begin
                        o_cmd.set_second = 1'b1;
                        n_state = S_START;
                    end else begin
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                o_cmd.mem_acc = 1'b1;
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap_read = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.set_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.set_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/core/tlpw_dpath.sv @@
// ----------------------------------------------------------------------------
// tlpw_dpath
// Datapath: item registers, byte-lane physical memory, entry decode and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpw_dpath import tlpw_pkg::*; #(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire [S_TDATA_W-1:0]   i_tdata,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [M_TDATA_W-1:0]  o_tdata
);

    localparam int AW    = MEM_ADDR_BITS;
    localparam int RW    = AW - 2;
    localparam int DEPTH = 1 << RW;

    logic        r_paging;
    logic [19:0] r_dir_base;

    t_op          r_op;
    logic [31:0]  r_addr;
    logic [31:0]  r_wdata;
    logic [2:0]   r_len;
    logic [2:0]   r_len1;
    logic         r_translate;
    logic         r_second;
    logic [AW-1:0] r_base1;
    logic [AW-1:0] r_base2;
    logic [31:0]  r_res_data;
    logic         r_res_fault;
    logic [31:0]  r_out_data;
    logic         r_out_fault;

    t_op          in_op;
    logic [31:0]  in_addr;
    logic [31:0]  in_wdata;
    logic [2:0]   in_len;
    logic [2:0]   n_len;
    logic [2:0]   n_len1;
    logic         n_translate;
    logic [12:0]  room;

    logic [31:0]  va;
    logic [31:0]  word;
    logic [31:0]  dir_ptr;
    logic [31:0]  tab_addr;
    logic [31:0]  pa_full;
    logic [RW-1:0] word_row;
    logic         is_write;

    logic [RW-1:0] lane_row [4];
    logic          lane_we  [4];
    logic [7:0]    lane_wd  [4];
    logic [7:0]    q        [4];
    logic [31:0]   n_rdata;

    assign in_op    = t_op'(i_tdata[1:0]);
    assign in_addr  = i_tdata[33:2];
    assign in_wdata = i_tdata[65:34];
    assign in_len   = i_tdata[68:66];

    always_comb begin
        n_len = (in_len > 3'd4) ? 3'd4 : in_len;
        n_translate = r_paging && ((in_op == OP_VREAD) || (in_op == OP_VWRITE));
        room = 13'h1000 - {1'b0, in_addr[11:0]};
        n_len1 = n_len;
        if (n_translate && (room < {10'd0, n_len})) begin
            n_len1 = room[2:0];
        end
    end

    assign is_write = r_op[0];
    assign va       = r_second ? (r_addr + {29'd0, r_len1}) : r_addr;
    assign word     = {q[3], q[2], q[1], q[0]};
    assign dir_ptr  = {r_dir_base, va[31:22], 2'b00};
    assign tab_addr = {word[31:12], va[21:12], 2'b00};
    assign pa_full  = {word[31:12], va[11:0]};
    assign word_row = i_cmd.walk_dir ? dir_ptr[AW-1:2] : tab_addr[AW-1:2];

    always_comb begin
        logic [1:0]    idx;
        logic [2:0]    idx3;
        logic [AW-1:0] pa;
        for (int l = 0; l < 4; l++) begin
            idx  = 2'(2'(l) - r_addr[1:0]);
            idx3 = {1'b0, idx};
            if (idx3 < r_len1) begin
                pa = r_base1 + AW'(idx3);
            end else begin
                pa = r_base2 + AW'(3'(idx3 - r_len1));
            end
            lane_row[l] = (i_cmd.walk_dir || i_cmd.walk_tab) ? word_row : pa[AW-1:2];
            lane_we[l]  = i_cmd.mem_acc && is_write && (idx3 < r_len);
            lane_wd[l]  = r_wdata[8*idx +: 8];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [7:0] r_mem [DEPTH];
        logic [7:0] r_q;

        always_ff @(posedge i_clk) begin
            if (lane_we[g]) begin
                r_mem[lane_row[g]] <= lane_wd[g];
            end
            r_q <= r_mem[lane_row[g]];
        end

        assign q[g] = r_q;
    end

    always_comb begin
        logic [1:0] lane;
        n_rdata = '0;
        for (int i = 0; i < 4; i++) begin
            lane = 2'(r_addr[1:0] + 2'(i));
            if (3'(i) < r_len) begin
                n_rdata[8*i +: 8] = q[lane];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging   <= 1'b0;
            r_dir_base <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAGING:   r_paging   <= i_cfg_data[0];
                CFG_DIR_BASE: r_dir_base <= i_cfg_data;
                default:      r_paging   <= r_paging;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_op        <= in_op;
            r_addr      <= in_addr;
            r_wdata     <= in_wdata;
            r_len       <= n_len;
            r_len1      <= n_len1;
            r_translate <= n_translate;
            r_second    <= 1'b0;
            r_base1     <= in_addr[AW-1:0];
            r_base2     <= '0;
            r_res_data  <= '0;
            r_res_fault <= 1'b0;
        end
        if (i_cmd.set_second) begin
            r_second <= 1'b1;
        end
        if (i_cmd.set_base) begin
            if (r_second) begin
                r_base2 <= pa_full[AW-1:0];
            end else begin
                r_base1 <= pa_full[AW-1:0];
            end
        end
        if (i_cmd.set_fault) begin
            r_res_fault <= 1'b1;
        end
        if (i_cmd.cap_read && !is_write) begin
            r_res_data <= n_rdata;
        end
        if (i_cmd.set_out) begin
            r_out_data  <= r_res_data;
            r_out_fault <= r_res_fault;
        end
    end

    assign o_stat.len_zero  = (r_len == 3'd0);
    assign o_stat.translate = r_translate;
    assign o_stat.split     = (r_len1 != r_len);
    assign o_stat.second    = r_second;
    assign o_stat.present   = q[0][0];

    assign o_tdata = {7'd0, r_out_fault, r_out_data};

endmodule

`default_nettype wire

@@ rtl/core/two_level_page_walk_mmu.sv @@
// A zero-length item goes straight to the result; an untranslated item skips
// the walk; a translated item takes a page walk, and a second one when the
// access crosses a page. One item at a time; the next is accepted the cycle
// after the result is loaded; an item's occupancy is set by the walk sequencer
// and the single read port of the byte-lane memory (one entry word a read).
// Synchronous active-low reset clears control and configuration; memory
// contents are undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
// two_level_page_walk_mmu
// Paged memory unit with a two-level table walk and split page-crossing
// accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_walk_mmu import tlpw_pkg::*; #(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // operation[1:0], address[33:2], write_data[65:34], length[68:66], zero
    input  wire [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // read_data[31:0], fault[32], zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_cmd  cmd;
    t_stat stat;

    tlpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tlpw_dpath #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tdata    (s_axis_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_tdata    (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/tlpw_checker.sv @@
// ----------------------------------------------------------------------------
// tlpw_checker
// Port-level checks of the paged memory unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpw_checker import tlpw_pkg::*; (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 s_axis_tvalid,
    input wire                 s_axis_tready,
    input wire                 m_axis_tvalid,
    input wire                 m_axis_tready,
    input wire [M_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item dropped or changed under stall");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another is in flight");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("faulted item carries read data");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:33] == '0)
        else $error("result padding not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind two_level_page_walk_mmu tlpw_checker u_tlpw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/page_walk_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_walk_checker
// Watches the configuration port and both streams of the paged memory unit.
// Keeps its own byte memory, paging switch and directory frame, works out the
// result of every accepted item and compares it with the results that leave
// the block, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module page_walk_checker import tlpw_pkg::*; #(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_s_axis_tvalid,
    input  wire                  i_s_axis_tready,
    // operation[1:0], address[33:2], write_data[65:34], length[68:66], zero
    input  wire [S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire                  i_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    // read_data[31:0], fault[32], zero
    input  wire [M_TDATA_W-1:0]  i_m_axis_tdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int MEM_BYTES   = 1 << MEM_ADDR_BITS;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fault;
    } t_mmu_result;

    typedef struct packed {
        logic        ok;
        logic [31:0] pa;
    } t_walk;

    logic [7:0]  shadow_mem [0:MEM_BYTES-1];
    logic        paging_on;
    logic [19:0] dir_frame;
    int          mismatches = 0;
    t_mmu_result expected_results [$];

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        if (mismatches < MAX_REPORTS)
            $display("%0t mismatch: %s got %h expected %h", $time, what, got_v, want_v);
        mismatches++;
    endtask

    function automatic logic [31:0] load_word(input logic [31:0] pa);
        logic [31:0] word;
        logic [31:0] byte_addr;
        int          i;
        for (i = 0; i < 4; i++) begin
            byte_addr = pa + 32'(i);
            word[8*i +: 8] = shadow_mem[byte_addr[MEM_ADDR_BITS-1:0]];
        end
        return word;
    endfunction

    function automatic t_walk walk_va(input logic [31:0] va);
        t_walk       w;
        logic [31:0] dir_entry;
        logic [31:0] tab_entry;
        w = '0;
        dir_entry = load_word({dir_frame, va[31:22], 2'b00});
        if (!dir_entry[0])
            return w;
        tab_entry = load_word({dir_entry[31:12], va[21:12], 2'b00});
        if (!tab_entry[0])
            return w;
        w.ok = 1'b1;
        w.pa = {tab_entry[31:12], va[11:0]};
        return w;
    endfunction

    function automatic t_mmu_result predict_access(input t_op op, input logic [31:0] addr,
                                                   input logic [31:0] wdata,
                                                   input logic [2:0] len_field);
        t_mmu_result res;
        t_walk       w;
        logic [2:0]  nbytes;
        logic [2:0]  first_len;
        logic        writes;
        logic [31:0] base_lo;
        logic [31:0] base_hi;
        logic [31:0] room;
        logic [31:0] pa;
        int          i;
        res = '0;
        nbytes = (len_field > 3'd4) ? 3'd4 : len_field;
        if (nbytes == 3'd0)
            return res;
        writes = (op == OP_VWRITE) || (op == OP_PWRITE);
        first_len = nbytes;
        base_lo = addr;
        base_hi = '0;
        if (paging_on && (op == OP_VREAD || op == OP_VWRITE)) begin
            room = 32'h1000 - {20'd0, addr[11:0]};
            if (room < 32'(nbytes))
                first_len = room[2:0];
            w = walk_va(addr);
            if (!w.ok) begin
                res.fault = 1'b1;
                return res;
            end
            base_lo = w.pa;
            if (first_len < nbytes) begin
                w = walk_va(addr + 32'(first_len));
                if (!w.ok) begin
                    res.fault = 1'b1;
                    return res;
                end
                base_hi = w.pa;
            end
        end
        for (i = 0; i < int'(nbytes); i++) begin
            pa = (i < int'(first_len)) ? base_lo + 32'(i)
                                       : base_hi + 32'(i - int'(first_len));
            if (writes)
                shadow_mem[pa[MEM_ADDR_BITS-1:0]] = wdata[8*i +: 8];
            else
                res.read_data[8*i +: 8] = shadow_mem[pa[MEM_ADDR_BITS-1:0]];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_mmu_result got;
        t_mmu_result want;
        if (!i_rst_n) begin
            paging_on = 1'b0;
            dir_frame = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PAGING:   paging_on = i_cfg_data[0];
                    CFG_DIR_BASE: dir_frame = i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.push_back(predict_access(t_op'(i_s_axis_tdata[1:0]),
                                                          i_s_axis_tdata[33:2],
                                                          i_s_axis_tdata[65:34],
                                                          i_s_axis_tdata[68:66]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.read_data = i_m_axis_tdata[31:0];
                got.fault = i_m_axis_tdata[32];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", got.read_data, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.fault !== want.fault)
                        report_mismatch("fault", {31'd0, got.fault}, {31'd0, want.fault});
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the two-level paged memory unit. Preloads the edge windows of
// every physical page with mostly present entry words, runs directed accesses
// over hand-built page tables, then random accesses kept inside those windows
// under several paging settings, with bursty input, a wandering output stall
// and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import tlpw_pkg::*;

    localparam int MEM_BITS        = 16;
    localparam int FRAME_BITS      = MEM_BITS - 12;
    localparam int MEM_FRAMES      = 1 << FRAME_BITS;
    localparam int HIGH_WORDS      = 4;
    localparam int WINDOW_WORDS    = 9;
    localparam int ITEMS_PER_PHASE = 360;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = MEM_FRAMES * WINDOW_WORDS + 450;
    localparam int LIMIT_CYCLES    = 2_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    wire                   s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready;
    wire  [M_TDATA_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b0;

    two_level_page_walk_mmu #(
        .MEM_ADDR_BITS(MEM_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    page_walk_checker #(
        .MEM_ADDR_BITS(MEM_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL two_level_page_walk_mmu");
            $finish;
        end
    end

    task automatic set_mmu_config(input logic paging, input logic [19:0] dir_frame);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PAGING;
        i_cfg_data <= CFG_DATA_W'(paging);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DIR_BASE;
        i_cfg_data <= dir_frame;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_item(input t_op op, input logic [31:0] addr, input logic [31:0] wdata,
                             input logic [2:0] nbytes);
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, nbytes, wdata, addr, op};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // entry index near either end of a table
    function automatic logic [9:0] pick_index;
        logic [9:0] ix;
        ix = 10'($urandom_range(3));
        if ($urandom_range(1) == 0)
            ix = 10'h3fc + ix;
        return ix;
    endfunction

    function automatic logic [11:0] pick_offset;
        logic [11:0] off;
        off = 12'($urandom_range(15));
        if ($urandom_range(1) == 0)
            off = 12'hff0 + off;
        return off;
    endfunction

    task automatic send_random_item;
        t_op         op;
        int          sel;
        logic [31:0] addr;
        logic [2:0]  nbytes;
        op   = t_op'($urandom_range(3));
        sel  = $urandom_range(99);
        addr = {pick_index(), pick_index(), pick_offset()};
        if (op inside {OP_PREAD, OP_PWRITE})
            addr[31:12] = 20'($urandom);
        if (sel < 5)
            addr = 32'hffffffff - 32'($urandom_range(7));
        nbytes = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
        send_item(op, addr, $urandom, nbytes);
    endtask

    initial begin : result_sink
        int results_seen;
        int ready_pct;
        int pattern_left;
        bit held;
        results_seen = 0;
        ready_pct    = 100;
        pattern_left = 0;
        held         = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                results_seen++;
            if (pattern_left == 0) begin
                ready_pct    = ($urandom_range(2) == 0) ? 100 : $urandom_range(20, 90);
                pattern_left = $urandom_range(20, 300);
            end
            pattern_left--;
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) < ready_pct);
            end
        end
    end

    initial begin : stimulus
        int          i;
        int          k;
        int          phase;
        logic [31:0] word;
        logic [31:0] addr;
        logic        paging_plan [NUM_PHASES];
        logic [19:0] frame_plan  [NUM_PHASES];

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_PAGING;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // preload the first and last words of every page, entry words mostly present
        set_mmu_config(1'b0, 20'h00000);
        for (i = 0; i < MEM_FRAMES; i++) begin
            for (k = 0; k < WINDOW_WORDS; k++) begin
                word = $urandom;
                if ($urandom_range(7) != 0)
                    word[0] = 1'b1;
                addr = $urandom;
                addr[MEM_BITS-1:12] = FRAME_BITS'(i);
                addr[11:0] = (k < HIGH_WORDS) ? 12'hff0 + 12'(4 * k)
                                              : 12'(4 * (k - HIGH_WORDS));
                send_item(k[0] ? OP_PWRITE : OP_VWRITE, addr, word, 3'd4);
            end
        end
        wait_drained;

        // directory in frame 3, tables in frames 5 and 6
        gaps_on = 1'b1;
        set_mmu_config(1'b1, 20'hf0003);
        send_item(OP_PWRITE, 32'h00003000, 32'h7a205001, 3'd4);
        send_item(OP_PWRITE, 32'h00003ffc, 32'h00006001, 3'd4);
        send_item(OP_PWRITE, 32'h00003004, 32'hfffffffe, 3'd4);
        send_item(OP_PWRITE, 32'h00005000, 32'h0000a001, 3'd4);
        send_item(OP_PWRITE, 32'h00005004, 32'h0000c000, 3'd4);
        send_item(OP_PWRITE, 32'h00006ffc, 32'hffffb001, 3'd4);
        send_item(OP_VWRITE, 32'h00000000, 32'hffffffff, 3'd4);
        send_item(OP_PREAD,  32'h0000a000, 32'h00000000, 3'd4);
        send_item(OP_VREAD,  32'h00000000, 32'h00000000, 3'd1);
        send_item(OP_VREAD,  32'h00400000, 32'h00000000, 3'd2);
        send_item(OP_VREAD,  32'h00001000, 32'h00000000, 3'd3);
        send_item(OP_VWRITE, 32'h00000ffe, 32'h12345678, 3'd4);
        send_item(OP_VREAD,  32'h00000ffc, 32'h00000000, 3'd4);
        send_item(OP_VWRITE, 32'hfffffffe, 32'ha5c30f96, 3'd4);
        send_item(OP_VREAD,  32'hfffffffe, 32'h00000000, 3'd4);
        send_item(OP_PREAD,  32'h0000bffe, 32'h00000000, 3'd2);
        send_item(OP_VREAD,  32'h00400000, 32'h00000000, 3'd0);
        send_item(OP_PWRITE, 32'hffffffff, 32'h01020304, 3'd7);
        send_item(OP_PREAD,  32'h0000ffff, 32'h00000000, 3'd5);
        send_item(OP_PREAD,  32'hffff0000, 32'h00000000, 3'd6);
        send_item(OP_VREAD,  32'h00000003, 32'h00000000, 3'd3);
        send_item(OP_VWRITE, 32'hfffff001, 32'h00000000, 3'd2);
        send_item(OP_VREAD,  32'hfffff000, 32'h00000000, 3'd4);
        send_item(OP_PWRITE, 32'h00008000, 32'h00000000, 3'd0);

        paging_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        frame_plan  = '{20'hf0003, 20'hfffff, 20'h00000, 20'($urandom), 20'h00000};
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained;
            set_mmu_config(paging_plan[phase], frame_plan[phase]);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (phase == 3 && i == ITEMS_PER_PHASE / 2)
                    wait_drained;
                send_random_item();
            end
        end

        wait_drained;
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS two_level_page_walk_mmu");
        else
            $display("FAIL two_level_page_walk_mmu");
        $finish;
    end

endmodule

`default_nettype wire
